// File: hw/rtl/kce_pkg.sv
// Shared constants and types for the keyframe curve evaluator.
`timescale 1ns / 1ps
package kce_pkg;

	localparam int MAX_KEYS  = 16;
	localparam int KEY_IDX_W = $clog2(MAX_KEYS);
	localparam int COUNT_W   = 5;
	localparam int TIME_W    = 17;
	localparam int LANE_W    = 16;
	localparam int VALUE_W   = 3 * LANE_W;
	localparam int OP_W      = 2;
	localparam int S_DATA_W  = 88;
	localparam int M_DATA_W  = VALUE_W;
	localparam int CFG_IDX_W = 1;

	typedef logic signed [LANE_W-1:0] lane_t;
	typedef logic [TIME_W-1:0]        key_time_t;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_TIME  = 2'd0,
		OP_WRITE_VALUE = 2'd1,
		OP_EVALUATE    = 2'd2,
		OP_NONE        = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_TIME_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_KEYS);
	localparam key_time_t          RATIO_ONE = 17'd65536;
	localparam lane_t              LANE_ONE  = 16'sd256;

endpackage

// File: hw/rtl/keyframe_curve_evaluator.sv
// Top level of the keyframe curve evaluator: sequencer, divider and shared multiplier.
`timescale 1ns / 1ps
// Piecewise linear keyframe curve. Load transactions (s_tuser = write time or
// write value) go straight into two 16-entry RAMs and leave the sequencer
// idle, so s_tready stays high. An evaluate transaction walks the key time
// RAM one entry per cycle to find the segment, runs a restoring divider one
// quotient bit per cycle for the 16-bit fraction, reads the two bounding
// values, then pushes the three lanes through one shared 17x18 multiplier
// (a multiply step and a round/saturate step per lane). A saturated fraction
// or a zero-length or reversed segment skips the divider. A ratio past the
// last key returns the last value; trivial curves skip the search and return
// 1.0 on every lane (no values) or the first value (one value or no times).
// s_tready is high only while the sequencer is idle, which it is again from
// the cycle in which the result is raised; a finished result waits in the
// final state until the output register is free. The result sits in an
// output register, so the next item is taken while a result still waits for
// m_tready. Table entries read before they were written return whatever the
// RAM holds. Key counts above 16 act as 16. Writes on the config port must
// happen while the block is idle.
module keyframe_curve_evaluator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// config: index 0 time_key_count, index 1 value_key_count
	input  logic                                    cfg_we,
	input  logic [kce_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [kce_pkg::COUNT_W-1:0]             cfg_data,
	// input stream
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// tdata: key_index[3:0], key_time[20:4], key_value_x[36:21],
	//        key_value_y[52:37], key_value_z[68:53], life_ratio[85:69], zero pad
	input  logic [kce_pkg::S_DATA_W-1:0]            s_tdata,
	// tuser: operation[1:0]
	input  logic [kce_pkg::OP_W-1:0]                s_tuser,
	// output stream
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// tdata: result_x[15:0], result_y[31:16], result_z[47:32]
	output logic [kce_pkg::M_DATA_W-1:0]            m_tdata
);

	import kce_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_TRD0   = 14'b00000000000010, // address key time 0
		ST_TFIRST = 14'b00000000000100, // key time 0 arrives
		ST_SRCH   = 14'b00000000001000, // one key time per cycle
		ST_DIVSET = 14'b00000000010000,
		ST_DIV    = 14'b00000000100000,
		ST_VRD0   = 14'b00000001000000,
		ST_VRD1   = 14'b00000010000000,
		ST_VRD2   = 14'b00000100000000,
		ST_VONE   = 14'b00001000000000, // single value lookup
		ST_VONEW  = 14'b00010000000000,
		ST_MUL    = 14'b00100000000000,
		ST_ACC    = 14'b01000000000000,
		ST_DONE   = 14'b10000000000000
	} state_t;

	localparam logic [1:0] LANE_X = 2'd0;
	localparam logic [1:0] LANE_Y = 2'd1;
	localparam logic [1:0] LANE_Z = 2'd2;

	localparam logic signed [17:0] FRAC_ONE   = 18'sd65536;
	localparam logic signed [34:0] ROUND_HALF = 35'sd32768;

	// input fields
	op_t                  in_op;
	logic [KEY_IDX_W-1:0] in_key_index;
	key_time_t            in_key_time;
	logic [VALUE_W-1:0]   in_values;
	key_time_t            in_ratio;
	logic                 in_accept;

	assign in_op        = op_t'(s_tuser);
	assign in_key_index = s_tdata[3:0];
	assign in_key_time  = s_tdata[20:4];
	assign in_values    = s_tdata[68:21]; // z,y,x with x lowest
	assign in_ratio     = s_tdata[85:69];
	assign in_accept    = s_tvalid && s_tready;

	// control state
	state_t               state_q;
	logic [COUNT_W-1:0]   time_key_count_q;
	logic [COUNT_W-1:0]   value_key_count_q;
	logic [COUNT_W-1:0]   tc_q;
	logic [COUNT_W-1:0]   vc_q;
	logic [COUNT_W-1:0]   idx_q;
	logic [3:0]           div_cnt_q;
	logic [1:0]           lane_q;
	logic                 m_tvalid_q;

	// datapath
	key_time_t            ratio_q;
	key_time_t            t_prev_q;
	logic signed [17:0]   dur_q;
	logic [TIME_W-1:0]    abs_q;
	logic                 neg_q;
	logic [TIME_W-1:0]    rem_q;
	logic [15:0]          quo_q;
	logic signed [17:0]   frac_q;
	logic [KEY_IDX_W-1:0] v0_q;
	logic [KEY_IDX_W-1:0] v1_q;
	logic [VALUE_W-1:0]   a_q;
	logic [VALUE_W-1:0]   b_q;
	logic signed [34:0]   prod_q;
	lane_t                res_q [3];
	logic [M_DATA_W-1:0]  out_q;

	// RAMs
	key_time_t            rd_time;
	logic [VALUE_W-1:0]   rd_value;
	logic [KEY_IDX_W-1:0] vaddr;

	assign vaddr = (state_q == ST_VRD1) ? v1_q : v0_q;

	kce_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_time_ram (
		.clk   (clk),
		.we    (in_accept && in_op == OP_WRITE_TIME),
		.waddr (in_key_index),
		.wdata (in_key_time),
		.raddr (idx_q[KEY_IDX_W-1:0]),
		.rdata (rd_time)
	);

	kce_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_KEYS)) u_value_ram (
		.clk   (clk),
		.we    (in_accept && in_op == OP_WRITE_VALUE),
		.waddr (in_key_index),
		.wdata (in_values),
		.raddr (vaddr),
		.rdata (rd_value)
	);

	// effective counts, clamped to the table size
	logic [COUNT_W-1:0] tc_eff;
	logic [COUNT_W-1:0] vc_eff;
	assign tc_eff = (time_key_count_q > COUNT_MAX) ? COUNT_MAX : time_key_count_q;
	assign vc_eff = (value_key_count_q > COUNT_MAX) ? COUNT_MAX : value_key_count_q;

	// segment search: rd_time holds key time k = idx_q - 1
	logic [COUNT_W-1:0] k_cur;
	logic [COUNT_W-1:0] k_prev;
	logic [COUNT_W-1:0] vmax;
	logic               seg_hit;
	logic               seg_last;
	logic signed [17:0] dur_d;
	logic signed [17:0] num_d;

	assign k_cur    = idx_q - COUNT_W'(1);
	assign k_prev   = idx_q - COUNT_W'(2);
	assign vmax     = vc_q - COUNT_W'(1);
	assign seg_hit  = ratio_q <= rd_time;
	assign seg_last = k_cur == tc_q - COUNT_W'(1);
	assign dur_d    = $signed({1'b0, rd_time}) - $signed({1'b0, t_prev_q});
	assign num_d    = $signed({1'b0, ratio_q}) - $signed({1'b0, t_prev_q});

	// restoring divider step
	logic [TIME_W:0]    div_r2;
	logic               div_ge;
	logic [TIME_W:0]    div_sub;
	logic [15:0]        quo_d;
	logic signed [17:0] frac_mag;

	assign div_r2   = {rem_q, 1'b0};
	assign div_ge   = div_r2 >= {1'b0, dur_q[TIME_W-1:0]};
	assign div_sub  = div_r2 - {1'b0, dur_q[TIME_W-1:0]};
	assign quo_d    = {quo_q[14:0], div_ge};
	assign frac_mag = $signed({2'b00, quo_d});

	// lane select for the shared multiplier
	lane_t a_lane;
	lane_t b_lane;
	always_comb begin
		case (lane_q)
			LANE_X: begin
				a_lane = a_q[15:0];
				b_lane = b_q[15:0];
			end
			LANE_Y: begin
				a_lane = a_q[31:16];
				b_lane = b_q[31:16];
			end
			default: begin
				a_lane = a_q[47:32];
				b_lane = b_q[47:32];
			end
		endcase
	end

	logic signed [16:0] diff;
	logic signed [34:0] prod_d;
	logic signed [34:0] rnd;
	logic signed [19:0] sum;
	lane_t              sat;

	assign diff   = $signed({b_lane[15], b_lane}) - $signed({a_lane[15], a_lane});
	assign prod_d = diff * frac_q;
	assign rnd    = prod_q + ROUND_HALF;
	assign sum    = $signed({{4{a_lane[15]}}, a_lane}) + $signed({rnd[34], rnd[34:16]});

	always_comb begin
		if (sum > 20'sd32767) begin
			sat = 16'sh7fff;
		end else if (sum < -20'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = sum[15:0];
		end
	end

	// finished result moves into the output register
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			time_key_count_q  <= '0;
			value_key_count_q <= '0;
			tc_q              <= '0;
			vc_q              <= '0;
			idx_q             <= '0;
			div_cnt_q         <= '0;
			lane_q            <= LANE_X;
			m_tvalid_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TIME_COUNT:  time_key_count_q  <= cfg_data;
					CFG_VALUE_COUNT: value_key_count_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && in_op == OP_EVALUATE) begin
						tc_q  <= tc_eff;
						vc_q  <= vc_eff;
						idx_q <= '0;
						if (vc_eff == '0) begin
							state_q <= ST_DONE;
						end else if (vc_eff == COUNT_W'(1) || tc_eff == '0) begin
							state_q <= ST_VONE;
						end else begin
							state_q <= ST_TRD0;
						end
					end
				end
				ST_TRD0: begin
					idx_q   <= COUNT_W'(1);
					state_q <= ST_TFIRST;
				end
				ST_TFIRST: begin
					if (tc_q == COUNT_W'(1)) begin
						state_q <= ST_VONE;
					end else begin
						idx_q   <= COUNT_W'(2);
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (seg_hit) begin
						state_q <= ST_DIVSET;
					end else if (seg_last) begin
						state_q <= ST_VONE;
					end else begin
						idx_q <= idx_q + COUNT_W'(1);
					end
				end
				ST_DIVSET: begin
					div_cnt_q <= '0;
					if (dur_q <= 18'sd0 || abs_q >= dur_q[TIME_W-1:0]) begin
						state_q <= ST_VRD0;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'd15) begin
						state_q <= ST_VRD0;
					end
				end
				ST_VRD0:  state_q <= ST_VRD1;
				ST_VRD1:  state_q <= ST_VRD2;
				ST_VRD2: begin
					lane_q  <= LANE_X;
					state_q <= ST_MUL;
				end
				ST_VONE:  state_q <= ST_VONEW;
				ST_VONEW: state_q <= ST_DONE;
				ST_MUL:   state_q <= ST_ACC;
				ST_ACC: begin
					lane_q <= lane_q + 2'd1;
					if (lane_q == LANE_Z) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					// wait for the output register to free up
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ratio_q <= (in_ratio > RATIO_ONE) ? RATIO_ONE : in_ratio;
				v0_q    <= '0;
				res_q[0] <= LANE_ONE;
				res_q[1] <= LANE_ONE;
				res_q[2] <= LANE_ONE;
			end
			ST_TFIRST: begin
				t_prev_q <= rd_time;
				v0_q     <= vmax[KEY_IDX_W-1:0];
			end
			ST_SRCH: begin
				t_prev_q <= rd_time;
				dur_q    <= dur_d;
				neg_q    <= num_d[17];
				abs_q    <= num_d[17] ? 17'(-num_d) : num_d[TIME_W-1:0];
				if (seg_hit) begin
					v0_q <= (k_prev < vmax) ? k_prev[KEY_IDX_W-1:0] : vmax[KEY_IDX_W-1:0];
					v1_q <= (k_cur < vmax) ? k_cur[KEY_IDX_W-1:0] : vmax[KEY_IDX_W-1:0];
				end else begin
					v0_q <= vmax[KEY_IDX_W-1:0];
				end
			end
			ST_DIVSET: begin
				rem_q <= abs_q;
				quo_q <= '0;
				if (dur_q <= 18'sd0) begin
					frac_q <= '0;
				end else begin
					// |ratio - t0| >= duration saturates at plus or minus one
					frac_q <= neg_q ? -FRAC_ONE : FRAC_ONE;
				end
			end
			ST_DIV: begin
				rem_q  <= div_ge ? div_sub[TIME_W-1:0] : div_r2[TIME_W-1:0];
				quo_q  <= quo_d;
				frac_q <= neg_q ? -frac_mag : frac_mag;
			end
			ST_VRD1: a_q <= rd_value;
			ST_VRD2: b_q <= rd_value;
			ST_VONEW: begin
				res_q[0] <= rd_value[15:0];
				res_q[1] <= rd_value[31:16];
				res_q[2] <= rd_value[47:32];
			end
			ST_MUL: prod_q <= prod_d;
			ST_ACC: res_q[lane_q] <= sat;
			ST_DONE: begin
				if (out_load) begin
					out_q <= {res_q[2], res_q[1], res_q[0]};
				end
			end
			default: ;
		endcase
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// a new result only comes out of the final state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final state");

	// divider remainder always stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < dur_q[TIME_W-1:0])
		else $error("divider remainder out of range");

	// blend fraction lies within [-1.0, 1.0]
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> (frac_q <= FRAC_ONE && frac_q >= -FRAC_ONE))
		else $error("fraction out of range");

	// the finished result is not overwritten while it waits
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_tvalid_q && !m_tready) |=> state_q == ST_DONE)
		else $error("pending result overwritten");

endmodule

// File: hw/rtl/kce_ram.sv
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
module kce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sim/keyframe_curve_evaluator_tb.sv
// Self-checking testbench for the keyframe curve evaluator: directed curve cases plus random curves.
`timescale 1ns / 1ps
module keyframe_curve_evaluator_tb;
	import kce_pkg::*;

	localparam int     CLK_HALF      = 2;
	localparam int     RESET_CYCLES  = 12;
	localparam int     RANDOM_ITEMS  = 600;
	// idle time the block is given after the last result
	localparam int     SETTLE_CYCLES = 64;
	localparam longint CYCLE_LIMIT   = 400000;
	localparam int     MAX_REPORTS   = 10;
	localparam longint FRAC_ONE      = 65536;

	// one result; x sits in the low bits, matching m_tdata
	typedef struct packed {
		lane_t z;
		lane_t y;
		lane_t x;
	} curve_point_t;

	typedef struct {
		op_t                  op;
		logic [KEY_IDX_W-1:0] key_index;
		key_time_t            key_time;
		lane_t                vx;
		lane_t                vy;
		lane_t                vz;
		key_time_t            life_ratio;
	} curve_item_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COUNT_W-1:0]   cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata   = '0;
	logic [OP_W-1:0]      s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;

	// shadow of the block: key tables and the two count registers
	key_time_t          time_mem [MAX_KEYS];
	curve_point_t       value_mem[MAX_KEYS];
	logic [COUNT_W-1:0] time_count  = '0;
	logic [COUNT_W-1:0] value_count = '0;
	curve_point_t       expected_points[$];

	int     mismatch_count = 0;
	int     eval_count     = 0;
	int     load_count     = 0;
	int     ignored_count  = 0;
	int     setting_count  = 0;
	int     burst_left     = 0;
	longint cycle_count    = 0;

	keyframe_curve_evaluator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// a + round_half_up((b - a) * frac / 1.0), saturated to Q8.8
	function automatic lane_t blend_lane(lane_t a, lane_t b, longint frac);
		longint prod;
		longint sum;
		prod = (longint'(b) - longint'(a)) * frac;
		sum  = longint'(a) + ((prod + 32768) >>> 16);
		if (sum > 32767)
			sum = 32767;
		if (sum < -32768)
			sum = -32768;
		return lane_t'(sum);
	endfunction

	function automatic curve_point_t evaluate_curve(key_time_t ratio_in);
		int unsigned  nt;
		int unsigned  nv;
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  i;
		longint       pos;
		longint       t0;
		longint       t1;
		longint       frac;
		curve_point_t pt;
		// counts above the table depth act as a full table
		nt = (time_count > MAX_KEYS) ? MAX_KEYS : time_count;
		nv = (value_count > MAX_KEYS) ? MAX_KEYS : value_count;
		if (nv == 0) begin
			pt.x = LANE_ONE;
			pt.y = LANE_ONE;
			pt.z = LANE_ONE;
		end else if (nv == 1 || nt == 0) begin
			pt = value_mem[0];
		end else begin
			pos = (ratio_in > RATIO_ONE) ? RATIO_ONE : ratio_in;
			// past the last key: hold the last value
			pt = value_mem[nv - 1];
			for (i = 0; i + 1 < nt; i++) begin
				if (pos <= time_mem[i + 1]) begin
					t0   = time_mem[i];
					t1   = time_mem[i + 1];
					// zero-length or reversed segment blends with a zero fraction
					frac = 0;
					if (t1 > t0) begin
						frac = ((pos - t0) * FRAC_ONE) / (t1 - t0);
						// before the first key the fraction bottoms out at -1.0
						if (frac < -FRAC_ONE)
							frac = -FRAC_ONE;
					end
					lo   = (i < nv - 1) ? i : nv - 1;
					hi   = (i + 1 < nv - 1) ? i + 1 : nv - 1;
					pt.x = blend_lane(value_mem[lo].x, value_mem[hi].x, frac);
					pt.y = blend_lane(value_mem[lo].y, value_mem[hi].y, frac);
					pt.z = blend_lane(value_mem[lo].z, value_mem[hi].z, frac);
					break;
				end
			end
		end
		return pt;
	endfunction

	// update the shadow for one accepted transaction
	function automatic void record_accepted(curve_item_t item);
		case (item.op)
			OP_WRITE_TIME: begin
				time_mem[item.key_index] = item.key_time;
				load_count++;
			end
			OP_WRITE_VALUE: begin
				value_mem[item.key_index].x = item.vx;
				value_mem[item.key_index].y = item.vy;
				value_mem[item.key_index].z = item.vz;
				load_count++;
			end
			OP_EVALUATE: begin
				expected_points.insert(expected_points.size(),
				                       evaluate_curve(item.life_ratio));
				eval_count++;
			end
			default: ignored_count++;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Random field sources
	// ------------------------------------------------------------------

	function automatic lane_t random_lane();
		case ($urandom_range(0, 7))
			0:       return 16'sh8000;
			1:       return 16'sh7FFF;
			default: return lane_t'($urandom);
		endcase
	endfunction

	function automatic curve_item_t random_item();
		curve_item_t item;
		item.op         = op_t'($urandom_range(0, 3));
		item.key_index  = KEY_IDX_W'($urandom_range(0, MAX_KEYS - 1));
		item.key_time   = key_time_t'($urandom_range(0, RATIO_ONE));
		item.vx         = random_lane();
		item.vy         = random_lane();
		item.vz         = random_lane();
		item.life_ratio = key_time_t'($urandom_range(0, 131071));
		return item;
	endfunction

	// ratios near the keys, the clamp edges and beyond 1.0
	function automatic key_time_t random_ratio();
		key_time_t t;
		t = time_mem[$urandom_range(0, MAX_KEYS - 1)];
		case ($urandom_range(0, 7))
			0:       return t;
			1:       return (t == 0) ? t : key_time_t'(t - 1);
			2:       return key_time_t'(t + 1);
			3:       return $urandom_range(0, 1) ? key_time_t'(0) : RATIO_ONE;
			4:       return key_time_t'($urandom_range(65537, 131071));
			default: return key_time_t'($urandom_range(0, RATIO_ONE));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Input side: bursts of transactions with random gaps between them
	// ------------------------------------------------------------------

	task automatic send_item(curve_item_t item);
		s_tvalid <= 1'b1;
		s_tuser  <= item.op;
		s_tdata  <= {2'b00, item.life_ratio, item.vz, item.vy, item.vx,
		             item.key_time, item.key_index};
		do @(posedge clk); while (!s_tready);
		record_accepted(item);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 48)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
			// some long bursts give stretches with no input idling
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(1, 6);
		end
	endtask

	// valid stays high inside a burst, so drop it before waiting on anything
	task automatic close_input();
		if (s_tvalid)
			s_tvalid <= 1'b0;
	endtask

	task automatic load_time(int idx, key_time_t t);
		curve_item_t item;
		item           = random_item();
		item.op        = OP_WRITE_TIME;
		item.key_index = KEY_IDX_W'(idx);
		item.key_time  = t;
		send_item(item);
	endtask

	task automatic load_value(int idx, lane_t vx, lane_t vy, lane_t vz);
		curve_item_t item;
		item           = random_item();
		item.op        = OP_WRITE_VALUE;
		item.key_index = KEY_IDX_W'(idx);
		item.vx        = vx;
		item.vy        = vy;
		item.vz        = vz;
		send_item(item);
	endtask

	task automatic evaluate_at(key_time_t ratio);
		curve_item_t item;
		item            = random_item();
		item.op         = OP_EVALUATE;
		item.life_ratio = ratio;
		send_item(item);
	endtask

	// wait until all results are back, then let any trailing load finish
	task automatic settle_block();
		close_input();
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both count registers, back to back; only called with the block idle
	task automatic set_counts(int tc, int vc);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TIME_COUNT;
		cfg_data  <= COUNT_W'(tc);
		@(posedge clk);
		time_count = COUNT_W'(tc);
		cfg_index <= CFG_VALUE_COUNT;
		cfg_data  <= COUNT_W'(vc);
		@(posedge clk);
		value_count = COUNT_W'(vc);
		cfg_we    <= 1'b0;
		setting_count++;
	endtask

	// ------------------------------------------------------------------
	// Output side: ready follows a rotating mask that is re-rolled now and
	// then; about a quarter of the masks are all ones (no stalls)
	// ------------------------------------------------------------------

	logic [7:0] ready_mask = 8'hFF;
	int         mask_age   = 0;

	always @(posedge clk) begin
		if (mask_age == 0) begin
			if ($urandom_range(0, 3) == 0)
				ready_mask <= 8'hFF;
			else
				ready_mask <= 8'($urandom_range(1, 255));
			mask_age <= $urandom_range(16, 96);
		end else begin
			ready_mask <= {ready_mask[0], ready_mask[7:1]};
			mask_age   <= mask_age - 1;
		end
		m_tready <= ready_mask[0];
	end

	// result checker: every output transaction against the oldest prediction
	always @(posedge clk) begin : check_results
		curve_point_t want;
		curve_point_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_points.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result with nothing pending: x=%0d y=%0d z=%0d",
					         $time, got.x, got.y, got.z);
			end else begin
				want = expected_points[0];
				expected_points.delete(0);
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
						         $time, want.x, want.y, want.z, got.x, got.y, got.z);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending",
			         cycle_count, expected_points.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// curves that never reach the segment search
	task automatic test_trivial_curves();
		// counts are zero out of reset: no values gives 1.0 everywhere
		evaluate_at(key_time_t'($urandom_range(0, 131071)));
		begin : unused_op
			curve_item_t item;
			item    = random_item();
			item.op = OP_NONE;
			send_item(item);
		end
		load_time(0, 17'd0);
		load_time(1, 17'd32768);
		load_time(2, RATIO_ONE);
		load_value(0, 16'sh8000, 16'sh7FFF, 16'sd0);
		load_value(1, 16'sh7FFF, 16'sh8000, LANE_ONE);
		load_value(2, 16'sd100, -16'sd100, -16'sd1);
		// a single value
		settle_block();
		set_counts(0, 1);
		evaluate_at(key_time_t'($urandom_range(0, 131071)));
		// no times
		settle_block();
		set_counts(0, 3);
		evaluate_at(17'd40000);
		// times but no values
		settle_block();
		set_counts(3, 0);
		evaluate_at(17'd40000);
	endtask

	// segment search, fraction edge cases and index capping
	task automatic test_segment_cases();
		settle_block();
		set_counts(3, 3);
		// full-scale swings between opposite lane extremes
		evaluate_at(17'd0);
		evaluate_at(17'd16384);
		evaluate_at(17'd32768);
		evaluate_at(17'd49153);
		evaluate_at(RATIO_ONE);
		evaluate_at(17'd65537);
		evaluate_at(17'd131071);
		// ratio ahead of the first key: negative fraction, clamped at -1.0
		load_time(0, 17'd20000);
		evaluate_at(17'd0);
		evaluate_at(17'd19999);
		// zero-length first segment
		load_time(1, 17'd20000);
		evaluate_at(17'd10000);
		evaluate_at(17'd20000);
		// reversed first segment
		load_time(1, 17'd10000);
		evaluate_at(17'd5000);
		// fewer values than times: upper value index is capped
		load_time(1, 17'd32768);
		settle_block();
		set_counts(3, 2);
		evaluate_at(17'd50000);
		// ratio beyond every key returns the last value
		load_time(2, 17'd40000);
		settle_block();
		set_counts(3, 3);
		evaluate_at(17'd60000);
	endtask

	// random key-count settings, each followed by a fresh sorted curve and
	// a run of evaluations with some noise mixed in
	task automatic test_random_curves();
		key_time_t          sorted_times[MAX_KEYS];
		key_time_t          swap;
		int                 tc;
		int                 vc;
		curve_item_t        noise;
		int                 base;
		int                 phase;
		int                 n;
		int                 k;
		int                 j;
		int                 roll;
		base  = load_count + eval_count;
		phase = 0;
		while (load_count + eval_count - base < RANDOM_ITEMS) begin
			settle_block();
			if (phase == 0) begin
				tc = MAX_KEYS;
				vc = MAX_KEYS;
			end else begin
				case ($urandom_range(0, 9))
					0: begin tc = 31; vc = 31; end
					1: begin tc = MAX_KEYS + 1; vc = $urandom_range(2, 31); end
					2: begin tc = $urandom_range(2, 31); vc = MAX_KEYS + 1; end
					3: begin tc = 2; vc = 2; end
					4: begin tc = $urandom_range(0, 31); vc = $urandom_range(0, 1); end
					default: begin
						tc = $urandom_range(2, MAX_KEYS);
						vc = $urandom_range(2, MAX_KEYS);
					end
				endcase
			end
			set_counts(tc, vc);
			// first pass fills both tables so no later count reads an unwritten entry
			n = (phase == 0) ? MAX_KEYS : $urandom_range(2, MAX_KEYS);
			for (k = 0; k < n; k++)
				sorted_times[k] = key_time_t'($urandom_range(0, RATIO_ONE));
			for (k = 1; k < n; k++)
				for (j = k; j > 0 && sorted_times[j - 1] > sorted_times[j]; j--) begin
					swap                = sorted_times[j];
					sorted_times[j]     = sorted_times[j - 1];
					sorted_times[j - 1] = swap;
				end
			if ($urandom_range(0, 2) == 0) begin
				sorted_times[0]     = '0;
				sorted_times[n - 1] = RATIO_ONE;
			end
			// an occasional repeated key gives a zero-length segment
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, n - 1);
				sorted_times[k] = sorted_times[k - 1];
			end
			for (k = 0; k < n; k++) begin
				load_time(k, sorted_times[k]);
				load_value(k, random_lane(), random_lane(), random_lane());
			end
			repeat ($urandom_range(20, 50)) begin
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					noise    = random_item();
					noise.op = OP_NONE;
					send_item(noise);
				end else if (roll < 12) begin
					// stray load, may break the ordering of the curve
					noise    = random_item();
					noise.op = $urandom_range(0, 1) ? OP_WRITE_TIME : OP_WRITE_VALUE;
					send_item(noise);
				end else begin
					evaluate_at(random_ratio());
				end
			end
			phase++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_trivial_curves();
		test_segment_cases();
		test_random_curves();
		settle_block();
		$display("Checked %0d curve evaluations against %0d key loads over %0d count settings",
		         eval_count, load_count, setting_count);
		$display("%0d unused-op items dropped, %0d result mismatches",
		         ignored_count, mismatch_count);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/kce_pkg.sv
hw/rtl/kce_ram.sv
hw/rtl/keyframe_curve_evaluator.sv
sim/keyframe_curve_evaluator_tb.sv
